// ----- hdl/sscmv_pkg.sv -----
// Shared types and codes for the complex symmetric sparse matrix-vector core.
// Used by sparse_sym_complex_mv_csc_core; depends on nothing.
`timescale 1ns / 1ps

package sscmv_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned CFG_W  = 3;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ENTRY = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [CFG_W-1:0] CFG_ALPHA_RE = 3'd0;
  localparam logic [CFG_W-1:0] CFG_ALPHA_IM = 3'd1;
  localparam logic [CFG_W-1:0] CFG_BETA_RE  = 3'd2;
  localparam logic [CFG_W-1:0] CFG_BETA_IM  = 3'd3;
  localparam logic [CFG_W-1:0] CFG_ROWS     = 3'd4;
  localparam logic [CFG_W-1:0] CFG_COLS     = 3'd5;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [IDX_W-1:0]        column_index;
    logic [IDX_W-1:0]        row_index;
    logic signed [DATA_W-1:0] x_real;
    logic signed [DATA_W-1:0] x_imag;
    logic signed [DATA_W-1:0] y_real_in;
    logic signed [DATA_W-1:0] y_imag_in;
    logic signed [DATA_W-1:0] value_real;
    logic signed [DATA_W-1:0] value_imag;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]        result_index;
    logic signed [DATA_W-1:0] y_real_out;
    logic signed [DATA_W-1:0] y_imag_out;
    logic                    status;
  } out_word_t;

endpackage

// ----- hdl/sparse_sym_complex_mv_csc_core.sv -----
// Complex symmetric sparse matrix-vector core, y = beta*y + alpha*A*x, Q16.16.
// Depends on sscmv_pkg for the word types, opcodes and register indexes.
`timescale 1ns / 1ps

// One word is taken at a time and the input stalls until its work is done. A load
// with a non-square size writes x and y as it is accepted; a scaled load forms
// alpha*x and beta*y and then writes y; a matrix entry below the diagonal makes two
// updates, each reading x and y, forming two complex products and writing y; an
// ignored entry or unknown opcode does no further work; a read waits for any output
// stall. One shared 33 by 33 bit multiplier forms the four partial products of each
// complex product in turn, with a register after it. The x and y stores are single
// memories with a registered read and need no clearing after reset.
module sparse_sym_complex_mv_csc_core #(
  parameter int unsigned MAX_DIM    = 1024,
  parameter int unsigned PART_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sscmv_pkg::CFG_W-1:0]   cfg_idx_i,
  input  logic [sscmv_pkg::DATA_W-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sscmv_pkg::in_word_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sscmv_pkg::out_word_t          out_data_o
);

  localparam int unsigned AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned PW  = PART_WIDTH;
  localparam int unsigned MW  = 2 * PW;
  localparam int unsigned OPW = 33;
  localparam int unsigned PRW = 2 * OPW;
  localparam int unsigned AC  = 51;
  localparam logic signed [AC-1:0] SAT_HI = (51'sd1 <<< (PW - 1)) - 51'sd1;
  localparam logic signed [AC-1:0] SAT_LO = -SAT_HI - 51'sd1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDX  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_WRY  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;

  function automatic logic signed [31:0] sat(input logic signed [AC-1:0] v);
    logic signed [AC-1:0] c;
    begin
      c = v;
      if (v > SAT_HI) c = SAT_HI;
      if (v < SAT_LO) c = SAT_LO;
      sat = c[31:0];
    end
  endfunction

  logic signed [31:0] alpha_re_q, alpha_im_q, beta_re_q, beta_im_q;
  logic [10:0]        rows_q, cols_q;

  logic [2:0]         state_q, state_d;
  logic [2:0]         k_q;
  logic               pass_q, half_q, is_load_q;
  logic [AW-1:0]      ci_q, ri_q;
  logic [9:0]         col_q;
  logic signed [31:0] it1_re_q, it1_im_q, it2_re_q, it2_im_q;
  logic signed [31:0] res0_re_q, res0_im_q, res1_re_q, res1_im_q;
  logic signed [PRW-1:0] prod_q;
  logic signed [AC-1:0]  acc_re_q, acc_im_q;
  logic [MW-1:0]      x_rd_q, y_rd_q;
  logic [MW-1:0]      x_mem [MAX_DIM];
  logic [MW-1:0]      y_mem [MAX_DIM];
  sscmv_pkg::out_word_t out_q;
  logic               out_valid_q;

  logic               accept, square, entry_ok, out_load;
  logic [AW-1:0]      in_ci, in_ri, dst, src, y_raddr, y_waddr;
  logic               y_we;
  logic [MW-1:0]      y_wdata;
  logic signed [31:0] ld_xr, ld_xi, ld_yr, ld_yi, ld_vr, ld_vi;
  logic signed [31:0] ar, ai, br, bi, ny_re, ny_im;
  logic signed [OPW-1:0] op_a, op_b;
  logic signed [PRW-1:0] prod_d;
  logic signed [AC-1:0]  fs, acc_re_n, acc_im_n;

  assign square   = (rows_q == cols_q);
  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_ci    = AW'(in_data_i.column_index % MAX_DIM);
  assign in_ri    = AW'(in_data_i.row_index % MAX_DIM);
  assign entry_ok = square && (in_data_i.row_index > in_data_i.column_index)
                    && ({1'b0, in_data_i.row_index} < cols_q);
  assign dst      = (half_q || is_load_q) ? ci_q : ri_q;
  assign src      = half_q ? ri_q : ci_q;
  assign y_raddr  = (state_q == ST_IDLE) ? in_ci : ((state_q == ST_RD) ? ci_q : dst);

  assign ld_xr = sat(AC'(in_data_i.x_real));
  assign ld_xi = sat(AC'(in_data_i.x_imag));
  assign ld_yr = sat(AC'(in_data_i.y_real_in));
  assign ld_yi = sat(AC'(in_data_i.y_imag_in));
  assign ld_vr = sat(AC'(in_data_i.value_real));
  assign ld_vi = sat(AC'(in_data_i.value_imag));

  // Operand selection for the shared multiplier.
  always_comb begin
    if (is_load_q) begin
      ar = pass_q ? beta_re_q : alpha_re_q;
      ai = pass_q ? beta_im_q : alpha_im_q;
      br = pass_q ? it2_re_q : it1_re_q;
      bi = pass_q ? it2_im_q : it1_im_q;
    end else begin
      ar = pass_q ? alpha_re_q : it1_re_q;
      ai = pass_q ? alpha_im_q : it1_im_q;
      br = pass_q ? res0_re_q : 32'(signed'(x_rd_q[MW-1:PW]));
      bi = pass_q ? res0_im_q : 32'(signed'(x_rd_q[PW-1:0]));
    end
    if (!is_load_q && !pass_q) begin
      op_a = (k_q[0] == 1'b0) ? OPW'(ar) : -OPW'(ai);
    end else begin
      op_a = (k_q[0] == 1'b0) ? OPW'(ar) : OPW'(ai);
    end
    op_b = (k_q == 3'd0 || k_q == 3'd3) ? OPW'(br) : OPW'(bi);
  end

  assign prod_d   = op_a * op_b;
  assign fs       = AC'(signed'(prod_q[PRW-1:16]));
  assign acc_re_n = (k_q == 3'd1) ? fs : acc_re_q - fs;
  assign acc_im_n = (k_q == 3'd3) ? fs : acc_im_q + fs;

  always_comb begin
    if (is_load_q) begin
      ny_re = sat(AC'(res0_re_q) + AC'(res1_re_q));
      ny_im = sat(AC'(res0_im_q) + AC'(res1_im_q));
    end else begin
      ny_re = sat(AC'(signed'(y_rd_q[MW-1:PW])) + AC'(res1_re_q));
      ny_im = sat(AC'(signed'(y_rd_q[PW-1:0])) + AC'(res1_im_q));
    end
  end

  always_comb begin
    y_we    = 1'b0;
    y_waddr = dst;
    y_wdata = {ny_re[PW-1:0], ny_im[PW-1:0]};
    if (accept && in_data_i.opcode == sscmv_pkg::OP_LOAD && !square) begin
      y_we    = 1'b1;
      y_waddr = in_ci;
      y_wdata = {ld_yr[PW-1:0], ld_yi[PW-1:0]};
    end else if (state_q == ST_WRY) begin
      y_we = 1'b1;
    end
  end

  assign out_load = (state_q == ST_RD) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.opcode == sscmv_pkg::OP_LOAD && square) begin
            state_d = ST_MUL;
          end else if (in_data_i.opcode == sscmv_pkg::OP_ENTRY && entry_ok) begin
            state_d = ST_RDX;
          end else if (in_data_i.opcode == sscmv_pkg::OP_READ) begin
            state_d = ST_RD;
          end
        end
      end
      ST_RDX: state_d = ST_MUL;
      ST_MUL: begin
        if (k_q == 3'd5 && pass_q) state_d = ST_WRY;
      end
      ST_WRY: state_d = (!is_load_q && !half_q) ? ST_RDX : ST_IDLE;
      ST_RD: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= 3'd0;
      pass_q      <= 1'b0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
      alpha_re_q  <= 32'sd65536;
      alpha_im_q  <= '0;
      beta_re_q   <= '0;
      beta_im_q   <= '0;
      rows_q      <= '0;
      cols_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sscmv_pkg::CFG_ALPHA_RE: alpha_re_q <= cfg_data_i;
          sscmv_pkg::CFG_ALPHA_IM: alpha_im_q <= cfg_data_i;
          sscmv_pkg::CFG_BETA_RE:  beta_re_q  <= cfg_data_i;
          sscmv_pkg::CFG_BETA_IM:  beta_im_q  <= cfg_data_i;
          sscmv_pkg::CFG_ROWS:     rows_q     <= cfg_data_i[10:0];
          sscmv_pkg::CFG_COLS:     cols_q     <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (accept) begin
        k_q    <= 3'd0;
        pass_q <= 1'b0;
        half_q <= 1'b0;
      end else if (state_q == ST_MUL) begin
        if (k_q == 3'd5) begin
          k_q    <= 3'd0;
          pass_q <= 1'b1;
        end else begin
          k_q <= k_q + 3'd1;
        end
      end else if (state_q == ST_WRY) begin
        k_q    <= 3'd0;
        pass_q <= 1'b0;
        half_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_load_q <= (in_data_i.opcode == sscmv_pkg::OP_LOAD);
      ci_q      <= in_ci;
      ri_q      <= in_ri;
      col_q     <= in_data_i.column_index;
      it1_re_q  <= (in_data_i.opcode == sscmv_pkg::OP_LOAD) ? ld_xr : ld_vr;
      it1_im_q  <= (in_data_i.opcode == sscmv_pkg::OP_LOAD) ? ld_xi : ld_vi;
      it2_re_q  <= ld_yr;
      it2_im_q  <= ld_yi;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
      if (k_q == 3'd1 || k_q == 3'd2) acc_re_q <= acc_re_n;
      if (k_q == 3'd3 || k_q == 3'd4) acc_im_q <= acc_im_n;
      if (k_q == 3'd5) begin
        if (pass_q) begin
          res1_re_q <= sat(acc_re_q);
          res1_im_q <= sat(acc_im_q);
        end else begin
          res0_re_q <= sat(acc_re_q);
          res0_im_q <= sat(acc_im_q);
        end
      end
    end
    if (out_load) begin
      out_q.result_index <= col_q;
      out_q.y_real_out   <= 32'(signed'(y_rd_q[MW-1:PW]));
      out_q.y_imag_out   <= 32'(signed'(y_rd_q[PW-1:0]));
      out_q.status       <= !square;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.opcode == sscmv_pkg::OP_LOAD) begin
      x_mem[in_ci] <= {ld_xr[PW-1:0], ld_xi[PW-1:0]};
    end
    x_rd_q <= x_mem[src];
  end

  always_ff @(posedge clk_i) begin
    if (y_we) begin
      y_mem[y_waddr] <= y_wdata;
    end
    y_rd_q <= y_mem[y_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> k_q <= 3'd5)
    else $error("multiplier step count out of range");

  a_rdx_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RDX |-> !is_load_q)
    else $error("x fetch outside a matrix entry");

  a_skip_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.opcode == sscmv_pkg::OP_ENTRY && !entry_ok |=> state_q == ST_IDLE)
    else $error("ignored entry started work");

  a_read_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD && !out_valid_q |=> out_valid_q)
    else $error("read word not presented");

endmodule

// ----- tb/sparse_sym_complex_mv_csc_core_test.sv -----
// Testbench for sparse_sym_complex_mv_csc_core: directed table, then random phases.
// Checks every read word against a typed value or its complex fixed-point predictor; needs sscmv_pkg.
`timescale 1ns / 1ps

module sparse_sym_complex_mv_csc_core_test;

  localparam int unsigned DIM = 1024;
  localparam int unsigned SETTLE = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    bit                   reconfig;
    sscmv_pkg::in_word_t  w;
    bit                   typed;
    sscmv_pkg::out_word_t o;
  } stim_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [sscmv_pkg::CFG_W-1:0]    cfg_idx_i = '0;
  logic [sscmv_pkg::DATA_W-1:0]   cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  sscmv_pkg::in_word_t            in_data_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  sscmv_pkg::out_word_t           out_data_o;

  sparse_sym_complex_mv_csc_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state.
  longint    x_re [DIM];
  longint    x_im [DIM];
  longint    y_re [DIM];
  longint    y_im [DIM];
  longint    alpha_re = 65536, alpha_im = 0, beta_re = 0, beta_im = 0;
  logic [10:0] n_rows = '0, n_cols = '0;

  sscmv_pkg::out_word_t y_reads_due [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic cmul(input longint ar, ai, br, bi, output longint re, im);
    re = sat32(((ar * br) >>> 16) - ((ai * bi) >>> 16));
    im = sat32(((ar * bi) >>> 16) + ((ai * br) >>> 16));
  endtask

  task automatic add_conj_product(int unsigned dst, longint vr, vi, int unsigned src);
    longint tr, ti, ur, ui;
    cmul(vr, -vi, x_re[src], x_im[src], tr, ti);
    cmul(alpha_re, alpha_im, tr, ti, ur, ui);
    y_re[dst] = sat32(y_re[dst] + ur);
    y_im[dst] = sat32(y_im[dst] + ui);
  endtask

  task automatic predict_word(input sscmv_pkg::in_word_t w, output bit has,
                              output sscmv_pkg::out_word_t o);
    bit square;
    longint ar, ai, br, bi;
    int unsigned c, r;
    square = (n_rows == n_cols);
    c = w.column_index;
    r = w.row_index;
    has = 1'b0;
    o = '0;
    case (w.opcode)
      sscmv_pkg::OP_LOAD: begin
        x_re[c] = w.x_real;
        x_im[c] = w.x_imag;
        if (square) begin
          cmul(alpha_re, alpha_im, w.x_real, w.x_imag, ar, ai);
          cmul(beta_re, beta_im, w.y_real_in, w.y_imag_in, br, bi);
          y_re[c] = sat32(ar + br);
          y_im[c] = sat32(ai + bi);
        end else begin
          y_re[c] = w.y_real_in;
          y_im[c] = w.y_imag_in;
        end
      end
      sscmv_pkg::OP_ENTRY: begin
        if (square && r > c && r < n_cols) begin
          add_conj_product(r, w.value_real, w.value_imag, c);
          add_conj_product(c, w.value_real, w.value_imag, r);
        end
      end
      sscmv_pkg::OP_READ: begin
        has = 1'b1;
        o.result_index = w.column_index;
        o.y_real_out = y_re[c][31:0];
        o.y_imag_out = y_im[c][31:0];
        o.status = !square;
      end
      default: ;
    endcase
  endtask

  // Sender: offers words in bursts of random length with random gaps.
  task automatic send_word(input sscmv_pkg::in_word_t w, input bit typed,
                           input sscmv_pkg::out_word_t typed_o);
    bit has;
    sscmv_pkg::out_word_t o;
    in_data_i <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(w, has, o);
    if (has) y_reads_due.push_back(typed ? typed_o : o);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (y_reads_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [31:0] ar, ai, br, bi, input logic [31:0] nr, nc);
    logic [31:0] vals [6];
    vals = '{ar, ai, br, bi, nr, nc};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[sscmv_pkg::CFG_W-1:0];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    alpha_re = longint'($signed(ar));
    alpha_im = longint'($signed(ai));
    beta_re = longint'($signed(br));
    beta_im = longint'($signed(bi));
    n_rows = nr[10:0];
    n_cols = nc[10:0];
  endtask

  function automatic sscmv_pkg::in_word_t mk(logic [1:0] op, int unsigned c, int unsigned r,
                                             logic [31:0] xr, xi, yr, yi, vr, vi);
    sscmv_pkg::in_word_t w;
    w.opcode = op;
    w.column_index = c[9:0];
    w.row_index = r[9:0];
    w.x_real = xr;
    w.x_imag = xi;
    w.y_real_in = yr;
    w.y_imag_in = yi;
    w.value_real = vr;
    w.value_imag = vi;
    return w;
  endfunction

  function automatic sscmv_pkg::out_word_t yv(int unsigned c, logic [31:0] re, im);
    sscmv_pkg::out_word_t o;
    o.result_index = c[9:0];
    o.y_real_out = re;
    o.y_imag_out = im;
    o.status = 1'b0;
    return o;
  endfunction

  function automatic logic [31:0] rand_part();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'(int'($urandom_range(0, 262144)) - 131072);
  endfunction

  function automatic logic [31:0] small_scale();
    return 32'(int'($urandom_range(0, 131072)) - 65536);
  endfunction

  // Receiver: stall pattern is redrawn at random from four modes; one long hold-off on request.
  initial begin
    int unsigned mode;
    bit held;
    mode = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
      end else begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 3);
          2: out_stall_i <= ($urandom_range(0, 9) < 7);
          default: out_stall_i <= (cycles % 5 < 2);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    sscmv_pkg::out_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (y_reads_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", out_data_o);
      end else begin
        e = y_reads_due.pop_front();
        if (out_data_o.result_index !== e.result_index ||
            out_data_o.y_real_out !== e.y_real_out ||
            out_data_o.y_imag_out !== e.y_imag_out ||
            out_data_o.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", e, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sparse_sym_complex_mv_csc_core test failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t s;
    int unsigned pool [$];
    int unsigned base, span, c, r, t;
    logic [31:0] ar, ai, br, bi, nr, nc;

    for (int i = 0; i < DIM; i++) begin
      x_re[i] = 0; x_im[i] = 0; y_re[i] = 0; y_im[i] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    s = '{1'b0, '0, 1'b0, '0};
    s.w = mk(sscmv_pkg::OP_LOAD, 0, 0, 32'h7FFFFFFF, 32'h80000000, 123, 456, 0, 0);
    rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0); s.typed = 1;
    s.o = yv(0, 32'h7FFFFFFF, 32'h80000000); rows.push_back(s); s.typed = 0;
    s.w = mk(sscmv_pkg::OP_LOAD, 1023, 1023, 32'h80000000, 32'h7FFFFFFF, '1, '1, '1, '1);
    rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0, 0); s.typed = 1;
    s.o = yv(1023, 32'h80000000, 32'h7FFFFFFF); rows.push_back(s); s.typed = 0;
    // With a zero size every entry lies outside the matrix.
    s.w = mk(sscmv_pkg::OP_ENTRY, 0, 1023, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000);
    rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_RSVD, 0, 0, '1, '1, '1, '1, '1, '1); rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0); s.typed = 1;
    s.o = yv(0, 32'h7FFFFFFF, 32'h80000000); rows.push_back(s); s.typed = 0;
    s.w = mk(sscmv_pkg::OP_LOAD, 'h2AA, 'h155, 32'h00010000, 32'hFFFF0000, 0, 0, 0, 0);
    rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_READ, 'h2AA, 0, 0, 0, 0, 0, 0, 0); s.typed = 1;
    s.o = yv('h2AA, 32'h00010000, 32'hFFFF0000); rows.push_back(s); s.typed = 0;
    s.w = mk(sscmv_pkg::OP_LOAD, 'h155, 'h2AA, 5, -5, 7, 7, 0, 0); rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_READ, 'h155, 0, 0, 0, 0, 0, 0, 0); s.typed = 1;
    s.o = yv('h155, 5, -5); rows.push_back(s); s.typed = 0;
    s.reconfig = 1;
    s.w = mk(sscmv_pkg::OP_LOAD, 0, 0, 32'h10000, 0, 32'h30000, 32'h10000, 0, 0);
    rows.push_back(s);
    s.reconfig = 0;
    s.w = mk(sscmv_pkg::OP_LOAD, 1, 0, 32'h20000, 32'hFFFF8000, 32'h7FFFFFFF, 32'h80000000,
             0, 0);
    rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_LOAD, 1023, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0);
    rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_ENTRY, 0, 1, 0, 0, 0, 0, 32'h18000, 32'h8000); rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_ENTRY, 1, 0, 0, 0, 0, 0, 32'h18000, 32'h8000); rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_ENTRY, 1, 1, 0, 0, 0, 0, 32'h18000, 32'h8000); rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_ENTRY, 0, 1023, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000);
    rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0); rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0, 0); rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_RSVD, 1023, 1023, 0, 0, 0, 0, 0, 0); rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_ENTRY, 1, 'h2AA, 0, 0, 0, 0, 32'h10000, 32'h10000);
    rows.push_back(s);
    s.w = mk(sscmv_pkg::OP_READ, 'h2AA, 0, 0, 0, 0, 0, 0, 0); rows.push_back(s);

    foreach (rows[i]) begin
      if (rows[i].reconfig) begin
        drain();
        set_regs(32'h8000, 32'h4000, 32'hFFFF0000, 0, DIM, DIM);
      end
      send_word(rows[i].w, rows[i].typed, rows[i].o);
    end

    for (int p = 0; p < 7; p++) begin
      drain();
      ar = small_scale(); ai = small_scale(); br = small_scale(); bi = small_scale();
      case (p)
        0: begin ar = 32'h10000; ai = 0; br = 0; bi = 0; nr = DIM; nc = DIM; span = DIM; end
        1: begin
          ar = 32'h7FFFFFFF; ai = 32'h80000000; br = 32'h80000000; bi = 32'h7FFFFFFF;
          nr = 16; nc = 16; span = 16;
        end
        2: begin nr = 5; nc = 7; span = 8; end
        3: begin nr = 0; nc = 0; span = 16; end
        4: begin nr = DIM; nc = 0; span = 32; end
        5: begin nr = 64; nc = 64; span = 64; end
        default: begin nr = DIM; nc = DIM; span = DIM; end
      endcase
      set_regs(ar, ai, br, bi, nr, nc);
      base = (span == DIM) ? 0 : $urandom_range(0, 3) * (span == 16 ? 0 : 1);
      pool.delete();
      for (int k = 0; k < 62; k++) begin
        if (p == 2 && k == 8) hold_req = 1'b1;
        t = (k < 8 || pool.size() == 0) ? 0 : $urandom_range(0, 99);
        if (t < 30) begin
          c = (base + $urandom_range(0, span - 1)) % DIM;
          pool.push_back(c);
          send_word(mk(sscmv_pkg::OP_LOAD, c, $urandom, rand_part(), rand_part(),
                       rand_part(), rand_part(), $urandom, $urandom), 1'b0, '0);
        end else if (t < 72) begin
          c = pool[$urandom_range(0, pool.size() - 1)];
          r = pool[$urandom_range(0, pool.size() - 1)];
          if (r < c && $urandom_range(0, 4) != 0) begin
            base = r; r = c; c = base; base = 0;
          end
          send_word(mk(sscmv_pkg::OP_ENTRY, c, r, $urandom, $urandom, $urandom, $urandom,
                       rand_part(), rand_part()), 1'b0, '0);
        end else if (t < 96) begin
          c = pool[$urandom_range(0, pool.size() - 1)];
          send_word(mk(sscmv_pkg::OP_READ, c, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom), 1'b0, '0);
        end else begin
          send_word(mk(sscmv_pkg::OP_RSVD, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom), 1'b0, '0);
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("sparse_sym_complex_mv_csc_core test passed");
    end else begin
      $display("sparse_sym_complex_mv_csc_core test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sscmv_pkg.sv
hdl/sparse_sym_complex_mv_csc_core.sv
tb/sparse_sym_complex_mv_csc_core_test.sv
